[rtl/core/tgb_pkg.sv]
// Shared types and constants for the text gap buffer.
// No dependencies; every module of the block but tgb_ram imports it.
package tgb_pkg;

  localparam int unsigned CAPACITY = 4096;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned CHAR_W   = 16;

  typedef enum logic [1:0] {
    OP_INSERT     = 2'd0,
    OP_REMOVE     = 2'd1,
    OP_REMOVE_END = 2'd2,
    OP_READ       = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE_RD,
    S_MOVE_WR,
    S_APPLY,
    S_READ,
    S_DONE
  } back_state_e;

  typedef struct packed {
    op_e               op;
    logic [LEN_W-1:0]  pos;
    logic [CHAR_W-1:0] ch;
    logic [LEN_W-1:0]  cnt;
    logic [LEN_W:0]    end_pos;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

[rtl/core/tgb_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tgb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/tgb_front.sv]
// Front end: accepts input beats and decodes them into edit commands.
// Depends on tgb_pkg.
module tgb_front
  import tgb_pkg::*;
(
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // position[12:0], character[28:13], remove_count[41:29]
  input  logic [1:0]  s_axis_tuser_i,  // operation[1:0]
  input  q_status_t   q_status_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  logic [LEN_W-1:0] pos;
  logic [LEN_W-1:0] cnt;

  assign pos = s_axis_tdata_i[12:0];
  assign cnt = s_axis_tdata_i[41:29];

  assign s_axis_tready_o = !q_status_i.full;
  assign push_o          = s_axis_tvalid_i && !q_status_i.full;

  always_comb begin
    cmd_o.op      = op_e'(s_axis_tuser_i);
    cmd_o.pos     = pos;
    cmd_o.ch      = s_axis_tdata_i[28:13];
    cmd_o.cnt     = cnt;
    cmd_o.end_pos = {1'b0, pos} + {1'b0, cnt};
  end

endmodule

[rtl/core/tgb_queue.sv]
// Two-entry command queue between the front end and the back end.
// Depends on tgb_pkg.
module tgb_queue
  import tgb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cmd_t      cmd_i,
  input  logic      pop_i,
  output q_status_t status_o,
  output cmd_t      cmd_o
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign do_push = push_i && (count_q != 2'd2);
  assign do_pop  = pop_i && (count_q != 2'd0);

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign status_o.valid = (count_q != 2'd0);
  assign status_o.full  = (count_q == 2'd2);
  assign cmd_o          = slot_q[rd_ptr_q];

endmodule

[rtl/core/tgb_back.sv]
// Back end: checks commands against the gap state, moves the gap, edits or reads
// the character store and holds the result beat. Depends on tgb_pkg and tgb_ram.
module tgb_back
  import tgb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  q_status_t   q_status_i,
  input  cmd_t        cmd_i,
  output logic        pop_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // read_data[15:0], text_length[28:16]
  output logic [1:0]  m_axis_tuser_o   // status[1:0]
);

  back_state_e       state_q, state_d;
  logic [LEN_W-1:0]  gs_q, gs_d;
  logic [LEN_W-1:0]  gl_q, gl_d;
  cmd_t              cmd_q, cmd_d;
  logic [LEN_W-1:0]  tgt_q, tgt_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  status_e           status_q, status_d;
  logic [CHAR_W-1:0] data_q, data_d;
  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] out_data_q, out_data_d;
  logic [LEN_W-1:0]  out_len_q, out_len_d;
  status_e           out_status_q, out_status_d;

  logic [LEN_W-1:0]  len;
  logic [LEN_W:0]    rem_end;
  status_e           hd_status;
  logic [LEN_W-1:0]  hd_tgt;
  logic [LEN_W-1:0]  hd_cnt;
  logic              out_free;
  logic              move_right;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  tgb_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign len        = LEN_W'(CAPACITY) - gl_q;
  assign out_free   = !out_valid_q || m_axis_tready_i;
  assign move_right = (gs_q < tgt_q);
  assign rem_end    = (cmd_i.op == OP_REMOVE_END) ? {1'b0, len} : cmd_i.end_pos;

  // Classify the command at the head of the queue.
  always_comb begin
    hd_status = ST_OK;
    hd_tgt    = cmd_i.pos;
    hd_cnt    = LEN_W'(rem_end - {1'b0, cmd_i.pos});
    unique case (cmd_i.op)
      OP_INSERT: begin
        if (cmd_i.pos > len) begin
          hd_status = ST_RANGE;
        end else if (gl_q == '0) begin
          hd_status = ST_FULL;
        end
      end
      OP_REMOVE, OP_REMOVE_END: begin
        hd_tgt = rem_end[LEN_W-1:0];
        if (cmd_i.pos > len || rem_end > {1'b0, len}) begin
          hd_status = ST_RANGE;
        end
      end
      OP_READ: begin
        if (cmd_i.pos >= len) begin
          hd_status = ST_RANGE;
        end
      end
      default: hd_status = ST_RANGE;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (q_status_i.valid) begin
          if (hd_status != ST_OK) begin
            state_d = S_DONE;
          end else if (cmd_i.op == OP_READ) begin
            state_d = S_READ;
          end else begin
            state_d = S_MOVE_RD;
          end
        end
      end
      S_MOVE_RD: state_d = (gs_q == tgt_q) ? S_APPLY : S_MOVE_WR;
      S_MOVE_WR: state_d = S_MOVE_RD;
      S_APPLY:   state_d = S_DONE;
      S_READ:    state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    pop_o        = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = gs_q[ADDR_W-1:0];
    ram_wdata    = ram_rdata;
    ram_raddr    = ADDR_W'(gs_q + gl_q);
    gs_d         = gs_q;
    gl_d         = gl_q;
    cmd_d        = cmd_q;
    tgt_d        = tgt_q;
    cnt_d        = cnt_q;
    status_d     = status_q;
    data_d       = data_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_data_d   = out_data_q;
    out_len_d    = out_len_q;
    out_status_d = out_status_q;
    unique case (state_q)
      S_IDLE: begin
        if (q_status_i.valid) begin
          pop_o    = 1'b1;
          cmd_d    = cmd_i;
          tgt_d    = hd_tgt;
          cnt_d    = hd_cnt;
          status_d = hd_status;
          data_d   = '0;
        end
        ram_raddr = (cmd_i.pos < gs_q) ? cmd_i.pos[ADDR_W-1:0]
                                       : ADDR_W'(cmd_i.pos + gl_q);
      end
      S_MOVE_RD: begin
        ram_raddr = move_right ? ADDR_W'(gs_q + gl_q) : ADDR_W'(gs_q - 1'b1);
      end
      S_MOVE_WR: begin
        ram_we = 1'b1;
        if (move_right) begin
          ram_waddr = gs_q[ADDR_W-1:0];
          gs_d      = gs_q + 1'b1;
        end else begin
          ram_waddr = ADDR_W'(gs_q + gl_q - 1'b1);
          gs_d      = gs_q - 1'b1;
        end
      end
      S_APPLY: begin
        if (cmd_q.op == OP_INSERT) begin
          ram_we    = 1'b1;
          ram_wdata = cmd_q.ch;
          gs_d      = gs_q + 1'b1;
          gl_d      = gl_q - 1'b1;
        end else begin
          gs_d = cmd_q.pos;
          gl_d = gl_q + cnt_q;
        end
      end
      S_READ: begin
        data_d = ram_rdata;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_data_d   = data_q;
          out_len_d    = len;
          out_status_d = status_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gs_q        <= '0;
      gl_q        <= LEN_W'(CAPACITY);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gs_q        <= gs_d;
      gl_q        <= gl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    tgt_q        <= tgt_d;
    cnt_q        <= cnt_d;
    status_q     <= status_d;
    data_q       <= data_d;
    out_data_q   <= out_data_d;
    out_len_q    <= out_len_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_len_q, out_data_q};
  assign m_axis_tuser_o  = out_status_q;

endmodule

[rtl/core/text_gap_buffer.sv]
// Gap buffer of 16-bit characters with a capacity of 4096 (tgb_pkg::CAPACITY).
// An insert or remove first moves the gap to the edit point, one character per step,
// each step being one read and one write on the single store RAM; a read needs no
// gap move. A two-entry command queue lets new beats be taken while an edit runs.
// The store needs no clearing after reset. Every beat gives one result with the length
// and a status; rejected edits (full or out of range) leave the text unchanged.
// Depends on tgb_pkg, tgb_front, tgb_queue and tgb_back.
module text_gap_buffer
  import tgb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // position[12:0], character[28:13], remove_count[41:29]
  input  logic [1:0]  s_axis_tuser_i,  // operation[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // read_data[15:0], text_length[28:16]
  output logic [1:0]  m_axis_tuser_o   // status[1:0]
);

  q_status_t q_status;
  logic      push;
  logic      pop;
  cmd_t      push_cmd;
  cmd_t      head_cmd;

  tgb_front u_front (
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .q_status_i     (q_status),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  tgb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .status_o(q_status),
    .cmd_o   (head_cmd)
  );

  tgb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_status_i     (q_status),
    .cmd_i          (head_cmd),
    .pop_o          (pop),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

endmodule

[dv/text_gap_buffer_tb.sv]
// Self-checking testbench for text_gap_buffer: directed and random edits, random source
// idles and sink stalls, checked beat by beat against a logical-text scoreboard.
// Depends on tgb_pkg and the text_gap_buffer RTL.
module text_gap_buffer_tb;
  import tgb_pkg::*;

  localparam int unsigned STALL_LIMIT = 60000;

  typedef struct {
    logic [CHAR_W-1:0] read_data;
    logic [LEN_W-1:0]  text_length;
    status_e           status;
  } text_result_t;

  class gap_text_sb;
    logic [CHAR_W-1:0] text_chars [CAPACITY];
    int unsigned       text_len;
    text_result_t      pending_results [$];
    int unsigned       errors;

    function void note_cmd(op_e op, int unsigned pos, logic [CHAR_W-1:0] ch, int unsigned cnt);
      text_result_t r;
      int unsigned  i;
      int unsigned  n;
      r.read_data = '0;
      r.status    = ST_OK;
      case (op)
        OP_INSERT: begin
          if (pos > text_len) begin
            r.status = ST_RANGE;
          end else if (text_len == CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            for (i = text_len; i > pos; i--) text_chars[i] = text_chars[i-1];
            text_chars[pos] = ch;
            text_len++;
          end
        end
        OP_REMOVE, OP_REMOVE_END: begin
          if (pos > text_len) begin
            r.status = ST_RANGE;
          end else begin
            n = (op == OP_REMOVE_END) ? text_len - pos : cnt;
            if (n > text_len - pos) begin
              r.status = ST_RANGE;
            end else begin
              for (i = pos; i + n < text_len; i++) text_chars[i] = text_chars[i+n];
              text_len -= n;
            end
          end
        end
        default: begin
          if (pos >= text_len) r.status = ST_RANGE;
          else r.read_data = text_chars[pos];
        end
      endcase
      r.text_length = text_len[LEN_W-1:0];
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [CHAR_W-1:0] data, logic [LEN_W-1:0] len, logic [1:0] st);
      text_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual data %h length %0d status %0d",
                 $time, data, len, st);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (data !== want.read_data) begin
        $display("%0t read_data: expected %h, actual %h", $time, want.read_data, data);
        errors++;
      end
      if (len !== want.text_length) begin
        $display("%0t text_length: expected %0d, actual %0d", $time, want.text_length, len);
        errors++;
      end
      if (st !== want.status) begin
        $display("%0t status: expected %0d, actual %0d", $time, want.status, st);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_axis_tvalid_o;
  logic        m_ready = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  gap_text_sb  sb = new;
  int unsigned src_idle_pct = 21;
  int unsigned snk_idle_pct = 57;
  int unsigned cursor = 0;
  int unsigned stall_cycles = 0;

  text_gap_buffer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      sb.check_result(m_axis_tdata_o[15:0], m_axis_tdata_o[28:16], m_axis_tuser_o);
    end
    m_ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL text_gap_buffer");
      $finish;
    end
  end

  task automatic send_cmd(input op_e op, input int unsigned pos, input logic [CHAR_W-1:0] ch,
                          input int unsigned cnt);
    while ($urandom_range(99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_tdata <= {6'd0, cnt[12:0], ch, pos[12:0]};
    s_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_cmd(op, pos, ch, cnt);
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending_results.size() != 0);
  endtask

  task automatic run_directed();
    send_cmd(OP_READ, 0, 16'h0000, 0);
    send_cmd(OP_REMOVE, 0, 16'h0000, 0);
    send_cmd(OP_REMOVE_END, 0, 16'h0000, 0);
    send_cmd(OP_INSERT, 1, 16'h5555, 0);
    send_cmd(OP_INSERT, 4096, 16'hAAAA, 4096);
    send_cmd(OP_REMOVE, 0, 16'h0000, 4096);
    send_cmd(OP_REMOVE_END, 4096, 16'h0000, 0);
    send_cmd(OP_INSERT, 0, 16'hFFFF, 0);
    send_cmd(OP_INSERT, 0, 16'h0000, 0);
    send_cmd(OP_INSERT, 2, 16'h8001, 0);
    send_cmd(OP_INSERT, 1, 16'h7FFE, 0);
    for (int i = 0; i <= 4; i++) send_cmd(OP_READ, i, 16'h0000, 0);
    send_cmd(OP_REMOVE, 1, 16'h0000, 2);
    send_cmd(OP_REMOVE, 1, 16'h0000, 2);
    send_cmd(OP_REMOVE, 3, 16'h0000, 0);
    send_cmd(OP_REMOVE, 2, 16'h0000, 0);
    send_cmd(OP_INSERT, 2, 16'h1234, 0);
    send_cmd(OP_REMOVE_END, 1, 16'h0000, 0);
    send_cmd(OP_READ, 0, 16'h0000, 0);
    send_cmd(OP_REMOVE_END, 0, 16'h0000, 0);
  endtask

  task automatic run_edits(input int unsigned n_items);
    int unsigned len;
    int unsigned pos;
    int unsigned cnt;
    int unsigned pick;
    logic [CHAR_W-1:0] ch;
    for (int unsigned k = 0; k < n_items; k++) begin
      len  = sb.text_len;
      pick = $urandom_range(99);
      ch   = CHAR_W'($urandom_range(65535));
      cnt  = $urandom_range(4096);
      if ($urandom_range(49) == 0) cursor = $urandom_range(len);
      if (cursor > len) cursor = len;
      pos = cursor + $urandom_range(6);
      pos = (pos > 3) ? pos - 3 : 0;
      if (pos > len) pos = len;
      if (pick < 45) begin
        send_cmd(OP_INSERT, pos, ch, cnt);
        cursor = pos + 1;
      end else if (pick < 70) begin
        send_cmd(OP_READ, (len > 0) ? $urandom_range(len - 1) : 0, ch, cnt);
      end else if (pick < 85) begin
        cnt = $urandom_range(3);
        if (pos + cnt > len) cnt = len - pos;
        send_cmd(OP_REMOVE, pos, ch, cnt);
        cursor = pos;
      end else if (pick < 88) begin
        send_cmd(OP_REMOVE_END, pos, ch, cnt);
        cursor = pos;
      end else begin
        case ($urandom_range(3))
          0: send_cmd(OP_INSERT, $urandom_range(4096, len + 1), ch, cnt);
          1: send_cmd(OP_READ, $urandom_range(4096, len), ch, cnt);
          2: send_cmd(OP_REMOVE, pos, ch, $urandom_range(4096, len - pos + 1));
          default: send_cmd(OP_REMOVE_END, $urandom_range(4096, len + 1), ch, cnt);
        endcase
      end
    end
  endtask

  task automatic run_far_edits();
    send_cmd(OP_INSERT, CAPACITY, 16'hBEEF, 0);
    send_cmd(OP_INSERT, 0, 16'hBEEF, 0);
    send_cmd(OP_INSERT, 2048, 16'hBEEF, 0);
    for (int i = 0; i < 16; i++) send_cmd(OP_READ, $urandom_range(CAPACITY - 1), 16'h0000, 0);
    send_cmd(OP_READ, CAPACITY - 1, 16'h0000, 0);
    send_cmd(OP_READ, CAPACITY, 16'h0000, 0);
    send_cmd(OP_REMOVE, 2000, 16'h0000, 1);
    send_cmd(OP_INSERT, 2000, 16'hC0DE, 0);
    send_cmd(OP_READ, 2000, 16'h0000, 0);
    send_cmd(OP_REMOVE_END, CAPACITY, 16'h0000, 0);
    send_cmd(OP_REMOVE, 0, 16'h0000, CAPACITY);
    send_cmd(OP_READ, 0, 16'h0000, 0);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_edits(333);
    wait_drained();
    src_idle_pct = 57;
    snk_idle_pct = 21;
    run_edits(333);
    wait_drained();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_edits(333);
    run_far_edits();
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS text_gap_buffer");
    end else begin
      $display("FAIL text_gap_buffer");
    end
    $finish;
  end

endmodule
